// ===== rtl/core/biquad_iir_sample_filter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Biquad core assertion macros
// Shared concurrent assertion wrappers for the biquad filter RTL.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_SAMPLE_FILTER_CORE_DEFINES_SVH
`define BIQUAD_IIR_SAMPLE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("biquad core assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BIQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("biquad core assertion failed");

`endif

// ===== rtl/core/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquad package
// Constants, coefficient set type and register codes for the biquad core.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned CoefWidth      = 25;
  localparam int unsigned InShift        = 6;
  localparam int unsigned OutShift       = 14;
  localparam int unsigned CfgIdxWidth    = 3;

  // Register index codes on the configuration port
  typedef enum logic [CfgIdxWidth-1:0] {
    RegB0,
    RegB1,
    RegB2,
    RegA1,
    RegA2
  } coef_idx_e;

  typedef struct packed {
    logic signed [CoefWidth-1:0] b0;
    logic signed [CoefWidth-1:0] b1;
    logic signed [CoefWidth-1:0] b2;
    logic signed [CoefWidth-1:0] a1;
    logic signed [CoefWidth-1:0] a2;
  } coef_t;

endpackage

// ===== rtl/core/biq_feedfwd.sv =====
// ----------------------------------------------------------------------------
// Biquad feed-forward stages
// Input register with input history, then the registered b0/b1/b2 sum.
// ----------------------------------------------------------------------------
`include "biquad_iir_sample_filter_core_defines.svh"

module biq_feedfwd #(
  parameter int unsigned SampleWidth = biq_pkg::SampleWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  biq_pkg::coef_t         coef_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [SampleWidth-1:0] sample_in_i,
  input  logic                   block_end_i,
  output logic                   ff_valid_o,
  output logic                   ff_block_end_o,
  output logic signed [biq_pkg::CoefWidth+SampleWidth-biq_pkg::InShift+2:0] ff_sum_o,
  input  logic                   ff_take_i
);
  import biq_pkg::*;

  localparam int unsigned XWidth   = SampleWidth - InShift;
  localparam int unsigned ProdW    = CoefWidth + XWidth;
  localparam int unsigned AccWidth = ProdW + 3;

  logic en1, en2, accept;
  logic signed [XWidth-1:0] x_in;

  // stage 1: current input and its two predecessors
  logic                     v1_q, be1_q;
  logic signed [XWidth-1:0] x0_q, x1_q, x2_q;
  // input history, advanced per accepted transaction
  logic signed [XWidth-1:0] xd1_q, xd2_q;

  // stage 2: feed-forward sum
  logic                       v2_q, be2_q;
  logic signed [AccWidth-1:0] ff_q, ff_d;
  logic signed [ProdW-1:0]    p0, p1, p2;

  assign en2        = !v2_q || ff_take_i;
  assign en1        = !v1_q || en2;
  assign accept     = in_valid_i && en1;
  assign in_stall_o = !en1;

  // floor shift is a plain slice
  assign x_in = $signed(sample_in_i[SampleWidth-1:InShift]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      xd1_q <= '0;
      xd2_q <= '0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (accept) begin
        xd1_q <= x_in;
        xd2_q <= xd1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q  <= x_in;
      x1_q  <= xd1_q;
      x2_q  <= xd2_q;
      be1_q <= block_end_i;
    end
  end

  assign p0   = ProdW'(coef_i.b0) * ProdW'(x0_q);
  assign p1   = ProdW'(coef_i.b1) * ProdW'(x1_q);
  assign p2   = ProdW'(coef_i.b2) * ProdW'(x2_q);
  assign ff_d = AccWidth'(p0) + AccWidth'(p1) + AccWidth'(p2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      ff_q  <= ff_d;
      be2_q <= be1_q;
    end
  end

  assign ff_valid_o     = v2_q;
  assign ff_block_end_o = be2_q;
  assign ff_sum_o       = ff_q;

  `BIQ_ASSERT_NXT(hist_shift_chk, clk_i, rst_ni, accept,
                  (x1_q == $past(xd1_q)) && (xd1_q == x0_q) && (xd2_q == x1_q))

endmodule

// ===== rtl/core/biq_feedback.sv =====
// ----------------------------------------------------------------------------
// Biquad feedback stage
// Subtracts a1/a2 terms, scales, saturates and holds the result register.
// ----------------------------------------------------------------------------
`include "biquad_iir_sample_filter_core_defines.svh"

module biq_feedback #(
  parameter int unsigned SampleWidth = biq_pkg::SampleWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  biq_pkg::coef_t         coef_i,
  input  logic                   ff_valid_i,
  input  logic                   ff_block_end_i,
  input  logic signed [biq_pkg::CoefWidth+SampleWidth-biq_pkg::InShift+2:0] ff_sum_i,
  output logic                   ff_take_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [SampleWidth-1:0] sample_out_o,
  output logic                   block_end_out_o
);
  import biq_pkg::*;

  localparam int unsigned XWidth   = SampleWidth - InShift;
  localparam int unsigned ProdW    = CoefWidth + XWidth;
  localparam int unsigned AccWidth = ProdW + 3;
  localparam int unsigned ShWidth  = AccWidth - OutShift;

  localparam logic signed [SampleWidth-1:0] SatMax = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic signed [SampleWidth-1:0] SatMin = {1'b1, {(SampleWidth-1){1'b0}}};

  logic en3, load;
  logic signed [ProdW-1:0]    pa1, pa2;
  logic signed [AccWidth-1:0] acc;
  logic signed [ShWidth-1:0]  acc_sh;
  logic                       in_range;
  logic signed [SampleWidth-1:0] y_d;

  logic                          v3_q, be3_q;
  logic signed [SampleWidth-1:0] y_q;
  logic signed [XWidth-1:0]      y1_q, y2_q;

  assign en3       = !v3_q || !out_stall_i;
  assign load      = en3 && ff_valid_i;
  assign ff_take_o = en3;

  assign pa1 = ProdW'(coef_i.a1) * ProdW'(y1_q);
  assign pa2 = ProdW'(coef_i.a2) * ProdW'(y2_q);
  assign acc = ff_sum_i - AccWidth'(pa1) - AccWidth'(pa2);

  // arithmetic shift by OutShift, then clamp to the sample range
  assign acc_sh   = acc[AccWidth-1:OutShift];
  assign in_range = (acc_sh[ShWidth-1:SampleWidth-1] == '0) ||
                    (acc_sh[ShWidth-1:SampleWidth-1] == '1);

  always_comb begin
    if (in_range) begin
      y_d = acc_sh[SampleWidth-1:0];
    end else if (acc_sh[ShWidth-1]) begin
      y_d = SatMin;
    end else begin
      y_d = SatMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      y1_q <= '0;
      y2_q <= '0;
    end else begin
      if (en3) begin
        v3_q <= ff_valid_i;
      end
      if (load) begin
        y1_q <= y_d[SampleWidth-1:InShift];
        y2_q <= y1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      y_q   <= y_d;
      be3_q <= ff_block_end_i;
    end
  end

  assign out_valid_o     = v3_q;
  assign sample_out_o    = y_q;
  assign block_end_out_o = be3_q;

  `BIQ_ASSERT_NXT(y1_tracks_out, clk_i, rst_ni, load,
                  y1_q == y_q[SampleWidth-1:InShift])
  `BIQ_ASSERT_NXT(y2_follows_y1, clk_i, rst_ni, load, y2_q == $past(y1_q))

endmodule

// ===== rtl/core/biquad_iir_sample_filter_core.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR sample filter core
// Fixed-point direct form I biquad with programmable coefficients.
// ----------------------------------------------------------------------------
// While the output is not stalled, the core takes one signed sample per
// clock and returns one filtered, saturated sample per clock for every
// sample taken. Input samples are shifted right by 6, combined with the two
// previous shifted inputs and the two previous outputs (also shifted right
// by 6) through five 25-bit coefficients with 20 fractional bits, shifted
// right by 14 (floor) and clamped to the signed sample range. Throughput is
// one transaction per cycle while out_stall_i is low. A sample passes three
// register stages: input, feed-forward sum, result. The a1/a2 feedback loop
// (two multiplies, subtract, clamp) is combinational between the output
// history registers and sets the clock limit. The block-end flag travels
// with its sample. Coefficients reset to zero and should be written only
// while the core is empty.
// ----------------------------------------------------------------------------
`include "biquad_iir_sample_filter_core_defines.svh"

module biquad_iir_sample_filter_core #(
  parameter int unsigned SampleWidth = biq_pkg::SampleWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [biq_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [biq_pkg::CoefWidth-1:0]  cfg_data_i,
  // sample input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SampleWidth-1:0]  sample_in_i,
  input  logic                           block_end_i,
  // sample output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SampleWidth-1:0]  sample_out_o,
  output logic                           block_end_out_o
);
  import biq_pkg::*;

  localparam int unsigned XWidth   = SampleWidth - InShift;
  localparam int unsigned AccWidth = CoefWidth + XWidth + 3;

  coef_t coef_q;

  logic                       ff_valid, ff_block_end, ff_take;
  logic signed [AccWidth-1:0] ff_sum;

  // Coefficient registers; indexes past the last coefficient are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      unique case (coef_idx_e'(cfg_idx_i))
        RegB0:   coef_q.b0 <= cfg_data_i;
        RegB1:   coef_q.b1 <= cfg_data_i;
        RegB2:   coef_q.b2 <= cfg_data_i;
        RegA1:   coef_q.a1 <= cfg_data_i;
        RegA2:   coef_q.a2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stages 1-2: input register, input history, b0/b1/b2 sum.
  biq_feedfwd #(
    .SampleWidth (SampleWidth)
  ) u_feedfwd (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .coef_i         (coef_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_in_i    (sample_in_i),
    .block_end_i    (block_end_i),
    .ff_valid_o     (ff_valid),
    .ff_block_end_o (ff_block_end),
    .ff_sum_o       (ff_sum),
    .ff_take_i      (ff_take)
  );

  // Stage 3: feedback terms, scaling, clamp, output register and history.
  biq_feedback #(
    .SampleWidth (SampleWidth)
  ) u_feedback (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .coef_i          (coef_q),
    .ff_valid_i      (ff_valid),
    .ff_block_end_i  (ff_block_end),
    .ff_sum_i        (ff_sum),
    .ff_take_o       (ff_take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o),
    .block_end_out_o (block_end_out_o)
  );

  // Input is only held off when the whole pipe is backed up behind the output.
  `BIQ_ASSERT_IMP(stall_only_when_full, clk_i, rst_ni, in_stall_o,
                  out_valid_o && out_stall_i && ff_valid)

endmodule
